// File: src/tmtl_pkg.sv
// Shared types, constants and helper functions for the mip tile layout block.
// Depends on nothing; the design files refer to it by scoped names, the bench imports it.
package tmtl_pkg;

  localparam int MAX_DIM    = 1024;
  localparam int MAX_LEVELS = 8;

  // Field widths of the descriptor and of the result records.
  localparam int DIM_W   = 11;
  localparam int SIZE_W  = 2;
  localparam int LEV_W   = 4;
  localparam int OFS_W   = 12;
  localparam int TILE_W  = 3;
  localparam int TOTAL_W = 21;
  localparam int STEP_W  = 12;
  localparam int LINE_W  = 9;
  localparam int TMEM_W  = 19;
  localparam int MASK_W  = 4;
  localparam int LR_W    = 13;

  // Block-load line step division: numerator and divisor widths.
  localparam int NUM_W = 16;
  localparam int DIV_W = 12;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TILE = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_4B  = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_8B  = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_16B = 2'd2;
  localparam logic [SIZE_W-1:0] SIZE_32B = 2'd3;

  // Classified descriptor as it travels from the front to the back.
  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [SIZE_W-1:0] sz;
    logic [LEV_W-1:0]  levels;
    logic              single;
    logic [OFS_W-1:0]  ofs;
  } cmd_t;

  // Queue head as the back sees it.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (32'(v) > MAX_DIM) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  // log2 of the texel group that one 64-bit word covers.
  function automatic logic [2:0] group_shift(input logic [SIZE_W-1:0] sz);
    logic [2:0] r;
    unique case (sz)
      SIZE_4B: r = 3'd4;
      SIZE_8B: r = 3'd3;
      default: r = 3'd2;
    endcase
    return r;
  endfunction

  // Words per line: width rounded up to the texel group, in groups.
  function automatic logic [DIM_W-1:0] line_of(input logic [DIM_W-1:0] w,
                                              input logic [SIZE_W-1:0] sz);
    logic [2:0]     gs;
    logic [DIM_W:0] gm;
    logic [DIM_W:0] sum;
    gs  = group_shift(sz);
    gm  = (DIM_W+1)'((1 << gs) - 1);
    sum = {1'b0, w} + gm;
    return DIM_W'(sum >> gs);
  endfunction

  // ceil(log2(n)) capped at 8: count the powers of two below n.
  function automatic logic [MASK_W-1:0] mask_bits(input logic [DIM_W-1:0] n);
    logic [MASK_W-1:0] k;
    k = '0;
    for (int j = 0; j < 8; j++) begin
      if (32'(n) > (1 << j)) k = k + MASK_W'(1);
    end
    return k;
  endfunction

  function automatic logic [DIM_W-1:0] halve(input logic [DIM_W-1:0] v);
    return (v >= DIM_W'(2)) ? (v >> 1) : v;
  endfunction

endpackage

// File: src/tmtl_if.sv
// Handshake channels of the mip tile layout block: descriptors in, records out.
// Depends on tmtl_pkg for field widths.
interface tmtl_desc_if;
  logic                          valid;
  logic                          ready;
  logic [tmtl_pkg::DIM_W-1:0]    width;
  logic [tmtl_pkg::DIM_W-1:0]    height;
  logic [tmtl_pkg::SIZE_W-1:0]   texel_size;
  logic [tmtl_pkg::LEV_W-1:0]    mip_levels;
  logic [tmtl_pkg::OFS_W-1:0]    coord_offset;

  modport source (output valid, width, height, texel_size, mip_levels, coord_offset,
                  input ready);
  modport sink   (input valid, width, height, texel_size, mip_levels, coord_offset,
                  output ready);
endinterface

interface tmtl_rec_if;
  logic                          valid;
  logic                          ready;
  logic                          record_kind;
  logic [tmtl_pkg::TILE_W-1:0]   tile_number;
  logic [tmtl_pkg::TOTAL_W-1:0]  texel_count_minus_one;
  logic [tmtl_pkg::STEP_W-1:0]   dxt_step;
  logic [tmtl_pkg::SIZE_W-1:0]   load_size_code;
  logic [tmtl_pkg::LINE_W-1:0]   line_words;
  logic [tmtl_pkg::TMEM_W-1:0]   tmem_offset;
  logic [tmtl_pkg::MASK_W-1:0]   mask_t;
  logic [tmtl_pkg::MASK_W-1:0]   mask_s;
  logic [tmtl_pkg::LR_W-1:0]     lower_right_s;
  logic [tmtl_pkg::LR_W-1:0]     lower_right_t;
  logic                          last;

  modport source (output valid, record_kind, tile_number, texel_count_minus_one, dxt_step,
                  load_size_code, line_words, tmem_offset, mask_t, mask_s,
                  lower_right_s, lower_right_t, last,
                  input ready);
  modport sink   (input valid, record_kind, tile_number, texel_count_minus_one, dxt_step,
                  load_size_code, line_words, tmem_offset, mask_t, mask_s,
                  lower_right_s, lower_right_t, last,
                  output ready);
endinterface

// File: src/tmtl_front.sv
// Front end: classify an incoming descriptor into a queue command.
// Depends on tmtl_pkg and tmtl_if.
module tmtl_front (
  tmtl_desc_if.sink      desc,
  input  logic           push_ok,
  output logic           push,
  output tmtl_pkg::cmd_t cmd
);

  logic [tmtl_pkg::LEV_W-1:0] lv_sat;

  assign desc.ready = push_ok;
  assign push       = desc.valid && push_ok;

  always_comb begin
    lv_sat = (32'(desc.mip_levels) > tmtl_pkg::MAX_LEVELS)
           ? tmtl_pkg::LEV_W'(tmtl_pkg::MAX_LEVELS) : desc.mip_levels;
    cmd.w      = tmtl_pkg::clamp_dim(desc.width);
    cmd.h      = tmtl_pkg::clamp_dim(desc.height);
    cmd.sz     = desc.texel_size;
    cmd.single = (lv_sat == '0);
    // a single-level texture still runs one level
    cmd.levels = (lv_sat == '0) ? tmtl_pkg::LEV_W'(1) : lv_sat;
    cmd.ofs    = desc.coord_offset;
  end

endmodule

// File: src/tmtl_queue.sv
// Short command queue between the front and the back.
// Depends on tmtl_pkg.
module tmtl_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tmtl_pkg::cmd_t    push_cmd,
  output logic              push_ok,
  input  logic              pop,
  output tmtl_pkg::q_head_t head
);

  tmtl_pkg::cmd_t                entries [tmtl_pkg::QUEUE_DEPTH];
  logic [tmtl_pkg::QPTR_W-1:0]   wr_ptr;
  logic [tmtl_pkg::QPTR_W-1:0]   rd_ptr;
  logic [tmtl_pkg::QCNT_W-1:0]   count;

  assign push_ok    = (count != tmtl_pkg::QCNT_W'(tmtl_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == tmtl_pkg::QUEUE_DEPTH - 1)
                ? '0 : wr_ptr + tmtl_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == tmtl_pkg::QUEUE_DEPTH - 1)
                ? '0 : rd_ptr + tmtl_pkg::QPTR_W'(1);
      end
      if (push && !pop) count <= count + tmtl_pkg::QCNT_W'(1);
      else if (pop && !push) count <= count - tmtl_pkg::QCNT_W'(1);
    end
  end

endmodule

// File: src/tmtl_back.sv
// Back end: sum the level sizes, divide for the line step, emit the records.
// Depends on tmtl_pkg and tmtl_if.
module tmtl_back (
  input  logic              clk,
  input  logic              rst,
  input  tmtl_pkg::q_head_t head,
  output logic              pop,
  tmtl_rec_if.source        rec
);

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_DIV, S_LOAD, S_TILE
  } state_t;

  state_t                          state;
  tmtl_pkg::cmd_t                  c;
  logic [tmtl_pkg::DIM_W-1:0]      w;
  logic [tmtl_pkg::DIM_W-1:0]      h;
  logic [tmtl_pkg::TILE_W-1:0]     lvl;
  logic [tmtl_pkg::TOTAL_W-1:0]    total;
  logic [tmtl_pkg::TMEM_W-1:0]     tmem;
  logic [tmtl_pkg::NUM_W-1:0]      num;
  logic [tmtl_pkg::DIV_W-1:0]      rem;
  logic [tmtl_pkg::DIV_W-1:0]      divisor;
  logic [tmtl_pkg::DCNT_W-1:0]     dcnt;
  logic                            ov;

  logic                            slot_free;
  logic                            emit;
  logic                            lvl_last;
  logic [tmtl_pkg::DIM_W-1:0]      line;
  logic [2*tmtl_pkg::DIM_W-1:0]    prod;
  logic [tmtl_pkg::DIV_W:0]        trial;
  logic [tmtl_pkg::DIV_W:0]        trial_sub;
  logic [tmtl_pkg::DIM_W+4:0]      d_wide;
  logic [tmtl_pkg::NUM_W:0]        num_wide;

  assign slot_free = !ov || rec.ready;
  assign emit      = slot_free && ((state == S_LOAD) || (state == S_TILE));
  assign rec.valid = ov;
  assign pop       = (state == S_IDLE) && head.valid;
  assign lvl_last  = ({1'b0, lvl} + tmtl_pkg::LEV_W'(1)) == c.levels;

  always_comb begin
    line      = tmtl_pkg::line_of(w, c.sz);
    prod      = line * h;
    trial     = {rem, num[tmtl_pkg::NUM_W-1]};
    trial_sub = trial - {1'b0, divisor};
    // divisor and numerator of the line step, from the base width
    d_wide    = (tmtl_pkg::DIM_W+5)'(tmtl_pkg::line_of(c.w, c.sz))
                << tmtl_pkg::group_shift(c.sz);
    num_wide  = (tmtl_pkg::NUM_W+1)'((1 << (15 - 32'(c.sz)))) +
                (tmtl_pkg::NUM_W+1)'(d_wide) - (tmtl_pkg::NUM_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov    <= 1'b0;
    end else begin
      // drop the held record once taken, unless a new one replaces it
      if (ov && rec.ready && !emit) ov <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            c     <= head.cmd;
            w     <= head.cmd.w;
            h     <= head.cmd.h;
            lvl   <= '0;
            total <= '0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          // add this level's block-load texels, then halve
          total <= total + tmtl_pkg::TOTAL_W'({prod, 2'b00});
          lvl   <= lvl + tmtl_pkg::TILE_W'(1);
          if (lvl_last) begin
            w       <= c.w;
            h       <= c.h;
            num     <= tmtl_pkg::NUM_W'(num_wide);
            divisor <= tmtl_pkg::DIV_W'(d_wide);
            rem     <= '0;
            dcnt    <= '0;
            state   <= c.single ? S_DIV : S_LOAD;
          end else begin
            w       <= tmtl_pkg::halve(w);
            h       <= tmtl_pkg::halve(h);
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle into num
          if (!trial_sub[tmtl_pkg::DIV_W]) begin
            rem <= tmtl_pkg::DIV_W'(trial_sub);
            num <= {num[tmtl_pkg::NUM_W-2:0], 1'b1};
          end else begin
            rem <= tmtl_pkg::DIV_W'(trial);
            num <= {num[tmtl_pkg::NUM_W-2:0], 1'b0};
          end
          dcnt <= dcnt + tmtl_pkg::DCNT_W'(1);
          if (32'(dcnt) == tmtl_pkg::NUM_W - 1) state <= S_LOAD;
        end
        S_LOAD: begin
          if (slot_free) begin
            ov                        <= 1'b1;
            rec.record_kind           <= tmtl_pkg::KIND_LOAD;
            rec.tile_number           <= '0;
            rec.texel_count_minus_one <= total - tmtl_pkg::TOTAL_W'(1);
            rec.dxt_step              <= c.single ? tmtl_pkg::STEP_W'(num) : '0;
            rec.load_size_code        <= (c.sz == tmtl_pkg::SIZE_32B)
                                         ? tmtl_pkg::SIZE_32B : tmtl_pkg::SIZE_16B;
            rec.line_words            <= '0;
            rec.tmem_offset           <= '0;
            rec.mask_t                <= '0;
            rec.mask_s                <= '0;
            rec.lower_right_s         <= '0;
            rec.lower_right_t         <= '0;
            rec.last                  <= 1'b0;
            lvl                       <= '0;
            tmem                      <= '0;
            state                     <= S_TILE;
          end
        end
        S_TILE: begin
          if (slot_free) begin
            ov                        <= 1'b1;
            rec.record_kind           <= tmtl_pkg::KIND_TILE;
            rec.tile_number           <= lvl;
            rec.texel_count_minus_one <= '0;
            rec.dxt_step              <= '0;
            rec.load_size_code        <= '0;
            rec.line_words            <= tmtl_pkg::LINE_W'(line);
            rec.tmem_offset           <= tmem;
            rec.mask_t                <= tmtl_pkg::mask_bits(h);
            rec.mask_s                <= tmtl_pkg::mask_bits(w);
            rec.lower_right_s         <= tmtl_pkg::LR_W'({w - tmtl_pkg::DIM_W'(1), 2'b00})
                                         + tmtl_pkg::LR_W'(c.ofs);
            rec.lower_right_t         <= tmtl_pkg::LR_W'({h - tmtl_pkg::DIM_W'(1), 2'b00})
                                         + tmtl_pkg::LR_W'(c.ofs);
            rec.last                  <= lvl_last;
            tmem                      <= tmem + tmtl_pkg::TMEM_W'(prod);
            w                         <= tmtl_pkg::halve(w);
            h                         <= tmtl_pkg::halve(h);
            lvl                       <= lvl + tmtl_pkg::TILE_W'(1);
            if (lvl_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/texture_mip_tile_layout_core.sv
// Top level of the mip-mapped texture memory tile layout block.
// Depends on tmtl_pkg, tmtl_if, tmtl_front, tmtl_queue and tmtl_back.

// Each accepted descriptor (base width and height, texel size code, mip level
// count, corner offset) produces one load record followed by one tile record
// per mip level, or a single tile record when the level count is zero; the
// final record of a run carries last. Zero dimensions read as 1, dimensions
// above the maximum saturate, and level counts above eight saturate. The back
// end works on one descriptor at a time; a single-level texture also takes its
// line step from a bit-serial divider producing one quotient bit per cycle. The
// per-level sum runs one level per cycle through a single small multiplier, and
// each record leaves through an output register, so a stalled sink holds the
// back end only when that register is still full. A two-entry queue lets the
// front accept up to two further descriptors while a run is in progress.
module texture_mip_tile_layout_core (
  input  logic        clk,
  input  logic        rst,
  tmtl_desc_if.sink   desc,
  tmtl_rec_if.source  rec
);

  // Front to queue.
  logic              push;
  logic              push_ok;
  tmtl_pkg::cmd_t    push_cmd;

  // Queue to back.
  tmtl_pkg::q_head_t head;
  logic              pop;

  // Clamp and classify the descriptor; accept only when the queue has room.
  tmtl_front u_front (
    .desc    (desc),
    .push_ok (push_ok),
    .push    (push),
    .cmd     (push_cmd)
  );

  // Hold classified descriptors until the back end is free.
  tmtl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .push_ok  (push_ok),
    .pop      (pop),
    .head     (head)
  );

  // Sequence the sum, the divide and the record output.
  tmtl_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .rec  (rec)
  );

endmodule

// File: bench/texture_mip_tile_layout_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for texture_mip_tile_layout_core: queued descriptors in, records checked.
// Depends on tmtl_pkg, tmtl_if and the core; predicts every record in-house.
module texture_mip_tile_layout_core_test;
  import tmtl_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 360;
  localparam int HOLD_AT      = 270;     // accepted descriptors before the long sink hold
  localparam int HOLD_CYCLES  = 500;
  localparam int TAIL_CYCLES  = 64;      // divider plus output register, with margin
  localparam int CYCLE_LIMIT  = 400000;

  // One descriptor waiting to go in, tagged with its idling phase.
  typedef struct {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [SIZE_W-1:0] texel_size;
    logic [LEV_W-1:0]  mip_levels;
    logic [OFS_W-1:0]  coord_offset;
    int                phase;        // 0: sink mostly stalls, 1: source mostly idles, 2: none
    bit                drain_first;  // hold this item until all owed records are back
  } desc_item_t;

  // One record as it leaves the block.
  typedef struct packed {
    logic               record_kind;
    logic [TILE_W-1:0]  tile_number;
    logic [TOTAL_W-1:0] texel_count_minus_one;
    logic [STEP_W-1:0]  dxt_step;
    logic [SIZE_W-1:0]  load_size_code;
    logic [LINE_W-1:0]  line_words;
    logic [TMEM_W-1:0]  tmem_offset;
    logic [MASK_W-1:0]  mask_t;
    logic [MASK_W-1:0]  mask_s;
    logic [LR_W-1:0]    lower_right_s;
    logic [LR_W-1:0]    lower_right_t;
    logic               last;
  } layout_rec_t;

  logic clk;
  logic rst;

  tmtl_desc_if desc_ch();
  tmtl_rec_if  rec_ch();

  texture_mip_tile_layout_core u_top (
    .clk  (clk),
    .rst  (rst),
    .desc (desc_ch),
    .rec  (rec_ch)
  );

  desc_item_t  pending_desc_q[$];   // descriptors not yet offered
  layout_rec_t layout_exp_q[$];     // records owed by the block, oldest first
  desc_item_t  offered;             // descriptor currently on the input channel

  int unsigned records_owed;        // records predicted so far
  int unsigned records_seen;        // records taken from the output so far
  int unsigned desc_taken;          // descriptors accepted so far
  int unsigned rx_idle_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned single_count;
  int unsigned chain_count;
  int unsigned odd_dim_count;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ceil(log2(n)), capped at eight.
  function automatic logic [MASK_W-1:0] mask_for(input int unsigned n);
    int unsigned k;
    k = 0;
    while (k < 8 && n > (32'd1 << k)) k++;
    return MASK_W'(k);
  endfunction

  function automatic string rec_text(input layout_rec_t r);
    return $sformatf({"kind=%0d tile=%0d cnt=%0d step=%0d lsz=%0d line=%0d tmem=%0d ",
                      "mt=%0d ms=%0d lrs=%0d lrt=%0d last=%0d"},
                     r.record_kind, r.tile_number, r.texel_count_minus_one, r.dxt_step,
                     r.load_size_code, r.line_words, r.tmem_offset, r.mask_t, r.mask_s,
                     r.lower_right_s, r.lower_right_t, r.last);
  endfunction

  // Work out the load record and the tile records of one descriptor, queue them,
  // and return how many were queued.
  function automatic int unsigned push_layout_records(input desc_item_t d);
    int unsigned w0, h0, lv, levels, gs, gm, w, h, total, tmem, line, k, dv;
    layout_rec_t r;
    // Zero reads as one; oversize saturates.
    w0 = (d.width == 0) ? 1 : ((d.width > MAX_DIM) ? MAX_DIM : d.width);
    h0 = (d.height == 0) ? 1 : ((d.height > MAX_DIM) ? MAX_DIM : d.height);
    lv = (d.mip_levels > MAX_LEVELS) ? MAX_LEVELS : d.mip_levels;
    levels = (lv == 0) ? 1 : lv;
    case (d.texel_size)
      SIZE_4B: gs = 4;
      SIZE_8B: gs = 3;
      default: gs = 2;
    endcase
    gm = (32'd1 << gs) - 1;

    // Load record: texel count summed over the halving chain.
    total = 0;
    w = w0;
    h = h0;
    for (int i = 0; i < levels; i++) begin
      total += ((w + gm) >> gs) * 4 * h;
      if (w >= 2) w >>= 1;
      if (h >= 2) h >>= 1;
    end
    r = '0;
    r.record_kind = KIND_LOAD;
    r.texel_count_minus_one = TOTAL_W'(total - 1);
    if (lv == 0) begin
      k  = 32'd1 << (15 - d.texel_size);
      dv = ((w0 + gm) >> gs) << gs;
      r.dxt_step = STEP_W'((k + dv - 1) / dv);
    end
    r.load_size_code = (d.texel_size == SIZE_32B) ? SIZE_32B : SIZE_16B;
    layout_exp_q.push_back(r);

    // Tile records, one per level; a side of one stays one.
    w = w0;
    h = h0;
    tmem = 0;
    for (int i = 0; i < levels; i++) begin
      if (i > 0) begin
        if (w >= 2) w >>= 1;
        if (h >= 2) h >>= 1;
      end
      line = (w + gm) >> gs;
      r = '0;
      r.record_kind   = KIND_TILE;
      r.tile_number   = TILE_W'(i);
      r.line_words    = LINE_W'(line);
      r.tmem_offset   = TMEM_W'(tmem);
      r.mask_t        = mask_for(h);
      r.mask_s        = mask_for(w);
      r.lower_right_s = LR_W'(((w - 1) << 2) + d.coord_offset);
      r.lower_right_t = LR_W'(((h - 1) << 2) + d.coord_offset);
      r.last          = (i + 1 == levels);
      layout_exp_q.push_back(r);
      tmem += line * h;
    end
    return levels + 1;
  endfunction

  task automatic add_desc(input int w, input int h, input logic [SIZE_W-1:0] sz,
                          input int lv, input int ofs, input int phase, input bit drain);
    desc_item_t d;
    d.width        = DIM_W'(w);
    d.height       = DIM_W'(h);
    d.texel_size   = sz;
    d.mip_levels   = LEV_W'(lv);
    d.coord_offset = OFS_W'(ofs);
    d.phase        = phase;
    d.drain_first  = drain;
    pending_desc_q.push_back(d);
    if (lv == 0) single_count++;
    else chain_count++;
    if (w == 0 || h == 0 || w > MAX_DIM || h > MAX_DIM) odd_dim_count++;
  endtask

  // Mostly small sides so most runs stay short; some full range and out of range.
  function automatic int pick_dim();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return $urandom_range(8, 1);
    if (roll < 65) return $urandom_range(64, 1);
    if (roll < 82) return $urandom_range(MAX_DIM, 1);
    if (roll < 88) return 32'd1 << $urandom_range(10);
    if (roll < 95) return $urandom_range(2047, MAX_DIM + 1);
    return 0;
  endfunction

  // Source side: offer queued descriptors, predict each one as it is accepted.
  always @(posedge clk) begin : drive_desc
    int unsigned added;
    int unsigned tx_pct;
    added = 0;
    if (rst) begin
      desc_ch.valid <= 1'b0;
      records_owed  <= 0;
      desc_taken    <= 0;
      rx_idle_pct   <= 86;
    end else begin
      if (desc_ch.valid && desc_ch.ready) begin
        added = push_layout_records(offered);
        records_owed <= records_owed + added;
        desc_taken   <= desc_taken + 1;
      end
      // Hold the item on the channel until it is taken.
      if (!(desc_ch.valid && !desc_ch.ready)) begin
        if (pending_desc_q.size() != 0) begin
          case (pending_desc_q[0].phase)
            0:       tx_pct = 8;
            1:       tx_pct = 86;
            default: tx_pct = 0;
          endcase
        end
        if (pending_desc_q.size() == 0 ||
            (pending_desc_q[0].drain_first && records_owed + added != records_seen) ||
            $urandom_range(99) < tx_pct) begin
          desc_ch.valid <= 1'b0;
        end else begin
          offered = pending_desc_q.pop_front();
          desc_ch.valid        <= 1'b1;
          desc_ch.width        <= offered.width;
          desc_ch.height       <= offered.height;
          desc_ch.texel_size   <= offered.texel_size;
          desc_ch.mip_levels   <= offered.mip_levels;
          desc_ch.coord_offset <= offered.coord_offset;
          case (offered.phase)
            0:       rx_idle_pct <= 86;
            1:       rx_idle_pct <= 8;
            default: rx_idle_pct <= 0;
          endcase
        end
      end
    end
  end

  // Sink side: random stalls, plus one long hold so the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      rec_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      rec_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && desc_taken >= HOLD_AT) begin
      rec_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      rec_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Check every accepted record against the oldest owed one.
  always @(posedge clk) begin : check_records
    layout_rec_t got;
    layout_rec_t want;
    if (rst) begin
      records_seen <= 0;
    end else if (rec_ch.valid && rec_ch.ready) begin
      got.record_kind           = rec_ch.record_kind;
      got.tile_number           = rec_ch.tile_number;
      got.texel_count_minus_one = rec_ch.texel_count_minus_one;
      got.dxt_step              = rec_ch.dxt_step;
      got.load_size_code        = rec_ch.load_size_code;
      got.line_words            = rec_ch.line_words;
      got.tmem_offset           = rec_ch.tmem_offset;
      got.mask_t                = rec_ch.mask_t;
      got.mask_s                = rec_ch.mask_s;
      got.lower_right_s         = rec_ch.lower_right_s;
      got.lower_right_t         = rec_ch.lower_right_t;
      got.last                  = rec_ch.last;
      records_seen <= records_seen + 1;
      if (layout_exp_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("record %0d not owed: %s", records_seen, rec_text(got));
      end else begin
        want = layout_exp_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("record %0d differs", records_seen);
            $display("  expected %s", rec_text(want));
            $display("  actual   %s", rec_text(got));
          end
        end
      end
    end
  end

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d records still owed",
               cycle_count, layout_exp_q.size());
      $display("texture_mip_tile_layout_core: mismatch");
      $finish;
    end
  end

  initial begin : run_sequence
    int phase;
    // Drive every input to a known value before the first edge.
    rst                  = 1'b1;
    desc_ch.valid        = 1'b0;
    desc_ch.width        = '0;
    desc_ch.height       = '0;
    desc_ch.texel_size   = '0;
    desc_ch.mip_levels   = '0;
    desc_ch.coord_offset = '0;
    rec_ch.ready         = 1'b0;
    cycle_count          = 0;
    mismatch_count       = 0;
    single_count         = 0;
    chain_count          = 0;
    odd_dim_count        = 0;

    // Directed: field extremes, every texel size, zero and oversize sides,
    // level count saturation, sides of one through the chain, extreme steps.
    add_desc(1,    1,    SIZE_4B,  0,  0,    0, 1'b0);
    add_desc(1024, 1024, SIZE_32B, 8,  4095, 0, 1'b0);
    add_desc(0,    0,    SIZE_8B,  1,  0,    0, 1'b0);
    add_desc(2047, 2047, SIZE_16B, 0,  4095, 0, 1'b0);
    add_desc(1025, 3,    SIZE_4B,  15, 1,    0, 1'b0);
    add_desc(3,    1025, SIZE_8B,  9,  2048, 0, 1'b0);
    add_desc(1024, 1,    SIZE_32B, 8,  7,    0, 1'b0);
    add_desc(1,    1024, SIZE_4B,  8,  100,  0, 1'b0);
    add_desc(17,   5,    SIZE_4B,  0,  3,    0, 1'b0);
    add_desc(5,    17,   SIZE_8B,  0,  2,    0, 1'b0);
    add_desc(1024, 1024, SIZE_32B, 0,  0,    0, 1'b0);
    add_desc(1,    1,    SIZE_32B, 0,  4095, 0, 1'b0);
    add_desc(1024, 1024, SIZE_4B,  8,  0,    0, 1'b0);
    add_desc(1023, 511,  SIZE_16B, 3,  1365, 0, 1'b0);
    add_desc(256,  256,  SIZE_8B,  8,  2730, 0, 1'b0);
    add_desc(2,    2,    SIZE_16B, 2,  1,    0, 1'b0);
    add_desc(1536, 0,    SIZE_32B, 4,  4094, 0, 1'b0);
    add_desc(1023, 1023, SIZE_4B,  7,  4095, 0, 1'b0);

    // Random: three idling phases; drain before each phase so the source
    // also sits idle until the block has handed back everything owed.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      int unsigned lv_roll;
      int lv;
      phase = (i < 110) ? 0 : ((i < 230) ? 1 : 2);
      lv_roll = $urandom_range(99);
      if (lv_roll < 30) lv = 0;
      else if (lv_roll < 88) lv = $urandom_range(MAX_LEVELS, 1);
      else lv = $urandom_range(15, MAX_LEVELS + 1);
      add_desc(pick_dim(), pick_dim(), SIZE_W'($urandom_range(3)), lv,
               $urandom_range(4095), phase, (i == 0 || i == 110 || i == 230));
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Sample on the falling edge so the clocked processes have settled.
    do @(negedge clk);
    while (pending_desc_q.size() != 0 || desc_ch.valid || records_owed != records_seen);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (layout_exp_q.size() != 0) begin
      mismatch_count++;
      $display("%0d records never arrived", layout_exp_q.size());
    end
    $display("covered %0d descriptors (%0d single-level, %0d mip chains, %0d zero or oversize)",
             desc_taken, single_count, chain_count, odd_dim_count);
    $display("checked %0d records across three idling phases and a %0d-cycle sink hold",
             records_seen, HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("texture_mip_tile_layout_core: match");
    end else begin
      $display("%0d records failed", mismatch_count);
      $display("texture_mip_tile_layout_core: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/tmtl_pkg.sv
src/tmtl_if.sv
src/tmtl_front.sv
src/tmtl_queue.sv
src/tmtl_back.sv
src/texture_mip_tile_layout_core.sv
bench/texture_mip_tile_layout_core_test.sv
